// File: src/rlfm_pkg.sv
package rlfm_pkg;

    // Number of protocol timers and their slots
    localparam int NUM_TIMERS = 3;
    localparam int TMR_T310   = 0;
    localparam int TMR_T311   = 1;
    localparam int TMR_T301   = 2;

    // Command codes of an input word
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_OOS     = 3'd1;
    localparam logic [2:0] CMD_INSYNC  = 3'd2;
    localparam logic [2:0] CMD_FAILURE = 3'd3;
    localparam logic [2:0] CMD_ANSWER  = 3'd4;

    // Event codes of a result word
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_T310_START = 3'd1;
    localparam logic [2:0] EV_LINK_OK    = 3'd2;
    localparam logic [2:0] EV_FAILURE    = 3'd3;
    localparam logic [2:0] EV_ATTEMPT    = 3'd4;
    localparam logic [2:0] EV_RECOVERED  = 3'd5;
    localparam logic [2:0] EV_ABORTED    = 3'd6;

    // Abort reasons
    localparam logic [1:0] ABORT_T301   = 2'd0;
    localparam logic [1:0] ABORT_T311   = 2'd1;
    localparam logic [1:0] ABORT_REJECT = 2'd2;

    // Failure cause used on T310 expiry
    localparam logic [2:0] CAUSE_T310 = 3'd1;

    // Configuration register indexes
    localparam logic [2:0] REG_T310_LIMIT = 3'd0;
    localparam logic [2:0] REG_T311_LIMIT = 3'd1;
    localparam logic [2:0] REG_T301_LIMIT = 3'd2;
    localparam logic [2:0] REG_N310       = 3'd3;
    localparam logic [2:0] REG_N311       = 3'd4;
    localparam logic [2:0] REG_MAX_ATT    = 3'd5;

    // Saturation value of the 8-bit counters
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // Configuration register file contents
    typedef struct packed {
        logic [15:0] t310_limit_ms;
        logic [15:0] t311_limit_ms;
        logic [15:0] t301_limit_ms;
        logic [7:0]  n310_count;
        logic [7:0]  n311_count;
        logic [7:0]  max_attempts;
    } t_cfg;

    // Fixed-width part of a result word
    typedef struct packed {
        logic [2:0] link_state;
        logic [2:0] event_code;
        logic       request_reestablish;
        logic       request_idle;
        logic [2:0] failure_cause;
        logic [1:0] abort_reason;
        logic [7:0] attempt_number;
    } t_result;

endpackage

// File: src/rlfm_cfg.sv
module rlfm_cfg
    import rlfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.t310_limit_ms <= 16'd1000;
            r_cfg.t311_limit_ms <= 16'd10000;
            r_cfg.t301_limit_ms <= 16'd1000;
            r_cfg.n310_count    <= 8'd1;
            r_cfg.n311_count    <= 8'd1;
            r_cfg.max_attempts  <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_T310_LIMIT: r_cfg.t310_limit_ms <= i_cfg_data;
                REG_T311_LIMIT: r_cfg.t311_limit_ms <= i_cfg_data;
                REG_T301_LIMIT: r_cfg.t301_limit_ms <= i_cfg_data;
                REG_N310:       r_cfg.n310_count    <= i_cfg_data[7:0];
                REG_N311:       r_cfg.n311_count    <= i_cfg_data[7:0];
                REG_MAX_ATT:    r_cfg.max_attempts  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/rlfm_core.sv
module rlfm_core
    import rlfm_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int STAT_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_fire,
    input  logic [2:0]           i_cmd,
    input  logic                 i_rrc_connected,
    input  logic [2:0]           i_failure_cause_in,
    input  logic                 i_reest_accepted,
    output t_result              o_result,
    output logic [STAT_BITS-1:0] o_failures_total,
    output logic [STAT_BITS-1:0] o_recoveries_total,
    output logic [STAT_BITS-1:0] o_aborts_total
);

    localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    typedef enum logic [2:0] {
        ST_NORMAL   = 3'd0,
        ST_OOS      = 3'd1,
        ST_T310     = 3'd2,
        ST_INSYNC   = 3'd3,
        ST_DETECTED = 3'd4,
        ST_REEST    = 3'd5
    } t_link_state;

    t_link_state             r_state, n_state;
    logic [7:0]              r_oos, n_oos;
    logic [7:0]              r_ins, n_ins;
    logic [NUM_TIMERS-1:0]   r_run, n_run;
    logic [TIMER_BITS-1:0]   r_el [NUM_TIMERS];
    logic [TIMER_BITS-1:0]   n_el [NUM_TIMERS];
    logic [7:0]              r_att, n_att;
    logic [2:0]              r_cause, n_cause;
    logic [1:0]              r_abort, n_abort;
    logic [STAT_BITS-1:0]    r_fail_cnt, n_fail_cnt;
    logic [STAT_BITS-1:0]    r_rec_cnt, n_rec_cnt;
    logic [STAT_BITS-1:0]    r_abort_cnt, n_abort_cnt;

    logic [2:0] ev;
    logic       req_reest;
    logic       req_idle;
    logic       do_fail;
    logic [2:0] fail_cause;
    logic       do_attempt;
    logic       do_abort;
    logic [1:0] abort_why;
    logic       exp_t310;
    logic       exp_t311;
    logic       exp_t301;

    // Next-state logic for one event word, in the order the protocol applies it.
    always_comb begin
        n_state     = r_state;
        n_oos       = r_oos;
        n_ins       = r_ins;
        n_run       = r_run;
        n_el        = r_el;
        n_att       = r_att;
        n_cause     = r_cause;
        n_abort     = r_abort;
        n_fail_cnt  = r_fail_cnt;
        n_rec_cnt   = r_rec_cnt;
        n_abort_cnt = r_abort_cnt;
        ev          = EV_NONE;
        req_reest   = 1'b0;
        req_idle    = 1'b0;
        do_fail     = 1'b0;
        fail_cause  = i_failure_cause_in;
        do_attempt  = 1'b0;
        do_abort    = 1'b0;
        abort_why   = ABORT_T301;

        // A tick advances every running timer, saturating.
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (i_cmd == CMD_TICK && r_run[i] && r_el[i] != TIMER_MAX) begin
                n_el[i] = r_el[i] + 1'b1;
            end
        end
        exp_t310 = n_run[TMR_T310] &&
                   CMP_BITS'(n_el[TMR_T310]) >= CMP_BITS'(i_cfg.t310_limit_ms);
        exp_t311 = n_run[TMR_T311] &&
                   CMP_BITS'(n_el[TMR_T311]) >= CMP_BITS'(i_cfg.t311_limit_ms);
        exp_t301 = n_run[TMR_T301] &&
                   CMP_BITS'(n_el[TMR_T301]) >= CMP_BITS'(i_cfg.t301_limit_ms);

        unique case (i_cmd)
            CMD_TICK: begin
                // At most one expiry is handled, T310 first.
                if (exp_t310) begin
                    do_fail    = 1'b1;
                    fail_cause = CAUSE_T310;
                end else if (exp_t311) begin
                    do_abort  = 1'b1;
                    abort_why = ABORT_T311;
                end else if (exp_t301) begin
                    n_run[TMR_T301] = 1'b0;
                    if (r_att < i_cfg.max_attempts) begin
                        do_attempt = 1'b1;
                        ev         = EV_ATTEMPT;
                    end else begin
                        do_abort  = 1'b1;
                        abort_why = ABORT_T301;
                    end
                end
            end
            CMD_OOS: begin
                if (i_rrc_connected) begin
                    n_ins = '0;
                    if (r_state == ST_NORMAL || r_state == ST_OOS) begin
                        n_oos   = (r_oos != CNT_MAX) ? r_oos + 8'd1 : CNT_MAX;
                        n_state = ST_OOS;
                        if (n_oos >= i_cfg.n310_count && !r_run[TMR_T310]) begin
                            n_run[TMR_T310] = 1'b1;
                            n_el[TMR_T310]  = '0;
                            n_state         = ST_T310;
                            ev              = EV_T310_START;
                        end
                    end else if (r_state == ST_INSYNC) begin
                        n_state = ST_T310;
                    end
                end
            end
            CMD_INSYNC: begin
                n_oos = '0;
                if (r_state == ST_T310 || r_state == ST_INSYNC) begin
                    n_ins   = (r_ins != CNT_MAX) ? r_ins + 8'd1 : CNT_MAX;
                    n_state = ST_INSYNC;
                    if (n_ins >= i_cfg.n311_count) begin
                        n_run[TMR_T310] = 1'b0;
                        n_state         = ST_NORMAL;
                        ev              = EV_LINK_OK;
                    end
                end
            end
            CMD_FAILURE: begin
                do_fail = 1'b1;
            end
            CMD_ANSWER: begin
                if (r_state == ST_REEST) begin
                    if (i_reest_accepted) begin
                        n_run     = '0;
                        n_rec_cnt = r_rec_cnt + 1'b1;
                        n_att     = '0;
                        n_state   = ST_NORMAL;
                        ev        = EV_RECOVERED;
                    end else begin
                        do_abort  = 1'b1;
                        abort_why = ABORT_REJECT;
                    end
                end
            end
            default: ;
        endcase

        // Declared failure: stop T310, start T311, then a first attempt.
        if (do_fail) begin
            n_run[TMR_T310] = 1'b0;
            n_cause         = fail_cause;
            n_fail_cnt      = r_fail_cnt + 1'b1;
            n_run[TMR_T311] = 1'b1;
            n_el[TMR_T311]  = '0;
            do_attempt      = 1'b1;
            ev              = EV_FAILURE;
        end

        // Re-establishment attempt guarded by T301.
        if (do_attempt) begin
            n_state         = ST_REEST;
            n_att           = (r_att != CNT_MAX) ? r_att + 8'd1 : CNT_MAX;
            n_run[TMR_T301] = 1'b1;
            n_el[TMR_T301]  = '0;
            req_reest       = 1'b1;
        end

        // Abort to idle clears all recovery state.
        if (do_abort) begin
            n_run       = '0;
            n_abort     = abort_why;
            n_abort_cnt = r_abort_cnt + 1'b1;
            n_state     = ST_NORMAL;
            n_oos       = '0;
            n_ins       = '0;
            n_att       = '0;
            ev          = EV_ABORTED;
            req_idle    = 1'b1;
        end
    end

    // State registers, updated once per event word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_NORMAL;
            r_oos       <= '0;
            r_ins       <= '0;
            r_run       <= '0;
            r_att       <= '0;
            r_cause     <= '0;
            r_abort     <= '0;
            r_fail_cnt  <= '0;
            r_rec_cnt   <= '0;
            r_abort_cnt <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_el[i] <= '0;
            end
        end else if (i_fire) begin
            r_state     <= n_state;
            r_oos       <= n_oos;
            r_ins       <= n_ins;
            r_run       <= n_run;
            r_el        <= n_el;
            r_att       <= n_att;
            r_cause     <= n_cause;
            r_abort     <= n_abort;
            r_fail_cnt  <= n_fail_cnt;
            r_rec_cnt   <= n_rec_cnt;
            r_abort_cnt <= n_abort_cnt;
        end
    end

    // Result word reflects the state after the event.
    assign o_result.link_state          = n_state;
    assign o_result.event_code          = ev;
    assign o_result.request_reestablish = req_reest;
    assign o_result.request_idle        = req_idle;
    assign o_result.failure_cause       = n_cause;
    assign o_result.abort_reason        = n_abort;
    assign o_result.attempt_number      = n_att;
    assign o_failures_total             = n_fail_cnt;
    assign o_recoveries_total           = n_rec_cnt;
    assign o_aborts_total               = n_abort_cnt;

endmodule

// File: src/radio_link_failure_monitor.sv
// Channel   | Direction | Handshake                  | Word
// ----------+-----------+----------------------------+---------------------------------
// input     | in        | i_in_valid / o_in_stall    | cmd, connected, cause, answer
// result    | out       | o_out_valid / i_out_stall  | state, event, requests, counters
// config    | in        | i_cfg_valid / o_cfg_ready  | register index, write data
//
// One event word is taken per cycle while o_in_stall is low; its result is
// presented once the single-pass update moves it from the input register
// into the result register. Reset is synchronous and clears all state,
// timers and statistics and loads the default configuration. A stall on the
// result side backs up into o_in_stall only once both registers hold a word.
module radio_link_failure_monitor
    import rlfm_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int STAT_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_cmd,
    input  logic                 i_rrc_connected,
    input  logic [2:0]           i_failure_cause_in,
    input  logic                 i_reest_accepted,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_link_state,
    output logic [2:0]           o_event_code,
    output logic                 o_request_reestablish,
    output logic                 o_request_idle,
    output logic [2:0]           o_failure_cause,
    output logic [1:0]           o_abort_reason,
    output logic [7:0]           o_attempt_number,
    output logic [STAT_BITS-1:0] o_failures_total,
    output logic [STAT_BITS-1:0] o_recoveries_total,
    output logic [STAT_BITS-1:0] o_aborts_total,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    t_cfg                 cfg;
    t_result              core_res;
    logic [STAT_BITS-1:0] core_fail;
    logic [STAT_BITS-1:0] core_rec;
    logic [STAT_BITS-1:0] core_abort;

    logic                 r_in_valid;
    logic [2:0]           r_cmd;
    logic                 r_conn;
    logic [2:0]           r_cause_in;
    logic                 r_acc;

    logic                 r_out_valid;
    t_result              r_res;
    logic [STAT_BITS-1:0] r_fail;
    logic [STAT_BITS-1:0] r_rec;
    logic [STAT_BITS-1:0] r_abort;

    logic                 out_free;
    logic                 fire;

    // Configuration is always ready to take a word.
    assign o_cfg_ready = 1'b1;

    rlfm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The input word moves on when the result register can take its result.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd      <= i_cmd;
            r_conn     <= i_rrc_connected;
            r_cause_in <= i_failure_cause_in;
            r_acc      <= i_reest_accepted;
        end
    end

    rlfm_core #(
        .TIMER_BITS (TIMER_BITS),
        .STAT_BITS  (STAT_BITS)
    ) u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_fire             (fire),
        .i_cmd              (r_cmd),
        .i_rrc_connected    (r_conn),
        .i_failure_cause_in (r_cause_in),
        .i_reest_accepted   (r_acc),
        .o_result           (core_res),
        .o_failures_total   (core_fail),
        .o_recoveries_total (core_rec),
        .o_aborts_total     (core_abort)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res   <= core_res;
            r_fail  <= core_fail;
            r_rec   <= core_rec;
            r_abort <= core_abort;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_link_state          = r_res.link_state;
    assign o_event_code          = r_res.event_code;
    assign o_request_reestablish = r_res.request_reestablish;
    assign o_request_idle        = r_res.request_idle;
    assign o_failure_cause       = r_res.failure_cause;
    assign o_abort_reason        = r_res.abort_reason;
    assign o_attempt_number      = r_res.attempt_number;
    assign o_failures_total      = r_fail;
    assign o_recoveries_total    = r_rec;
    assign o_aborts_total        = r_abort;

endmodule
